// ===== rtl/wcp_pkg.sv =====
// Package: shared constants, types and a helper function of the wavelet coefficient path block.
package wcp_pkg;

  localparam int MaxLayers = 8;
  localparam int StepW     = 16;
  localparam int LeafW     = MaxLayers - 1;
  localparam int LayerW    = $clog2(MaxLayers);
  localparam int LayersW   = 4;
  localparam int CoeffW    = 17;
  localparam int NodeW     = 19;
  localparam int Log2W     = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int RecipW    = 17;
  localparam int RecipSh   = 18;
  localparam int ProdW     = CoeffW + RecipW;

  localparam logic [CfgIdxW-1:0] CFG_NUM_TIME_STEPS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_LAYERS     = 2'd1;

  localparam logic [RecipW-1:0] DIV3_RECIP = 17'd87382;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_SPLIT,
    ST_DIV,
    ST_ROOT,
    ST_LAYER
  } state_t;

  typedef enum logic [1:0] {
    DIV_2,
    DIV_3,
    DIV_4
  } div_t;

  typedef struct packed {
    logic load_item;
    logic group;
    logic split;
    logic divide;
    logic root;
    logic layer;
  } wcp_cmd_t;

  typedef struct packed {
    logic no_layers;
    logic root_last;
    logic layer_last;
    logic out_free;
  } wcp_stat_t;

  function automatic logic [Log2W-1:0] floor_log2(input logic [StepW-1:0] v);
    logic [Log2W-1:0] r;
    r = '0;
    for (int i = 1; i < StepW; i++) begin
      if (v[i]) begin
        r = Log2W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/wcp_if.sv =====
// Interfaces: item, result and configuration channels of the wavelet coefficient path block.
interface wcp_item_if;
  import wcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [StepW-1:0]  step_number;
  logic [LeafW-1:0]  leaf_index;
  modport source(output valid, step_number, leaf_index, input ready);
  modport sink(input valid, step_number, leaf_index, output ready);
endinterface

interface wcp_result_if;
  import wcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [LayerW-1:0] layer_number;
  logic [CoeffW-1:0] coeff_index;
  logic              last_of_path;
  modport source(output valid, layer_number, coeff_index, last_of_path, input ready);
  modport sink(input valid, layer_number, coeff_index, last_of_path, output ready);
endinterface

interface wcp_cfg_if;
  import wcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/wcp_ctrl.sv =====
// Controller: state machine sequencing grouping, division and per-layer path steps.
module wcp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  wcp_pkg::wcp_stat_t stat,
  output wcp_pkg::wcp_cmd_t  cmd
);
  import wcp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          if (!stat.no_layers) begin
            state_next = ST_GROUP;
          end
        end
      end
      ST_GROUP: begin
        cmd.group  = 1'b1;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.divide = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (stat.out_free) begin
          cmd.root   = 1'b1;
          state_next = stat.root_last ? ST_IDLE : ST_LAYER;
        end
      end
      ST_LAYER: begin
        if (stat.out_free) begin
          cmd.layer = 1'b1;
          if (stat.layer_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wcp_datapath.sv =====
// Datapath: configuration registers, step-to-node mapping, path node update and result register.
module wcp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [wcp_pkg::StepW-1:0]   step_number,
  input  logic [wcp_pkg::LeafW-1:0]   leaf_index,
  input  wcp_pkg::wcp_cmd_t           cmd,
  output wcp_pkg::wcp_stat_t          stat,
  wcp_result_if.source                result,
  wcp_cfg_if.sink                     cfg
);
  import wcp_pkg::*;

  logic [StepW-1:0]       num_time_steps;
  logic [LayersW-1:0]     num_layers;

  logic [StepW-1:0]       step;
  logic [LeafW-1:0]       leaf_sh;
  logic [LayerW-1:0]      lm1;
  logic                   grp3;
  logic signed [NodeW-1:0] short_groups;
  logic [CoeffW-1:0]      x;
  div_t                   dsel;
  logic signed [NodeW-1:0] base;
  logic [CoeffW-1:0]      q;
  logic signed [NodeW-1:0] node;
  logic [LayerW-1:0]      cnt;

  logic                   out_valid;
  logic [LayerW-1:0]      out_layer;
  logic [CoeffW-1:0]      out_coeff;
  logic                   out_last;

  logic [LayersW-1:0]     eff;
  logic [Log2W-1:0]       n2;
  logic [CoeffW-1:0]      p2n;
  logic [CoeffW-1:0]      p2n1;
  logic                   grp3_next;
  logic signed [NodeW-1:0] short_groups_next;
  logic signed [NodeW-1:0] sg;
  logic signed [NodeW-1:0] step_s;
  logic [ProdW-1:0]       prod;
  logic [CoeffW-1:0]      q_next;
  logic signed [NodeW-1:0] half;
  logic                   lo;
  logic                   right;
  logic signed [NodeW-1:0] val;
  logic [LayerW-1:0]      cnt_inc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_time_steps <= StepW'(1);
      num_layers     <= LayersW'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NUM_TIME_STEPS: num_time_steps <= cfg.data[StepW-1:0];
        CFG_NUM_LAYERS:     num_layers     <= cfg.data[LayersW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff = (num_layers > LayersW'(MaxLayers)) ? LayersW'(MaxLayers) : num_layers;

  assign n2        = floor_log2(num_time_steps);
  assign p2n       = CoeffW'(1) << n2;
  assign p2n1      = (n2 == '0) ? '0 : (CoeffW'(1) << (n2 - Log2W'(1)));
  assign grp3_next = {1'b0, num_time_steps} > (p2n + p2n1);
  assign short_groups_next = grp3_next
      ? $signed(NodeW'(p2n1) << 2) - $signed(NodeW'(num_time_steps))
      : $signed(NodeW'(p2n1) + (NodeW'(p2n1) << 1)) - $signed(NodeW'(num_time_steps));

  assign sg     = grp3 ? (short_groups + (short_groups <<< 1)) : (short_groups <<< 1);
  assign step_s = $signed(NodeW'(step));

  assign prod = ProdW'(x) * ProdW'(DIV3_RECIP);

  always_comb begin
    case (dsel)
      DIV_2:   q_next = x >> 1;
      DIV_3:   q_next = CoeffW'(prod >> RecipSh);
      DIV_4:   q_next = x >> 2;
      default: q_next = x;
    endcase
  end

  assign half    = $signed(NodeW'(1) << cnt);
  assign lo      = node[NodeW-1] | ((node & half) == '0);
  assign right   = leaf_sh[LeafW-1];
  assign cnt_inc = cnt + LayerW'(1);

  always_comb begin
    if (lo) begin
      val = right ? ((node + half) <<< 1) : (node <<< 1);
    end else begin
      val = right ? ((node <<< 1) + NodeW'(1)) : (((node - half) <<< 1) + NodeW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      step    <= step_number;
      lm1     <= LayerW'(eff - LayersW'(1));
      leaf_sh <= LeafW'(leaf_index << (LayersW'(MaxLayers) - eff));
    end
    if (cmd.group) begin
      grp3         <= grp3_next;
      short_groups <= short_groups_next;
    end
    if (cmd.split) begin
      if (step_s < sg) begin
        x    <= CoeffW'(step);
        dsel <= grp3 ? DIV_3 : DIV_2;
        base <= '0;
      end else begin
        x    <= CoeffW'(step_s - sg);
        dsel <= grp3 ? DIV_4 : DIV_3;
        base <= short_groups;
      end
    end
    if (cmd.divide) begin
      q <= q_next;
    end
    if (cmd.root) begin
      node <= base + $signed(NodeW'(q));
      cnt  <= '0;
    end
    if (cmd.layer) begin
      node    <= val >>> 1;
      cnt     <= cnt_inc;
      leaf_sh <= leaf_sh << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.root || cmd.layer) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root) begin
      out_layer <= '0;
      out_coeff <= CoeffW'(step);
      out_last  <= (lm1 == '0);
    end else if (cmd.layer) begin
      out_layer <= cnt_inc;
      out_coeff <= val[CoeffW-1:0];
      out_last  <= (cnt_inc == lm1);
    end
  end

  assign result.valid        = out_valid;
  assign result.layer_number = out_layer;
  assign result.coeff_index  = out_coeff;
  assign result.last_of_path = out_last;

  assign stat.no_layers  = (num_layers == '0);
  assign stat.root_last  = (lm1 == '0);
  assign stat.layer_last = (cnt_inc == lm1);
  assign stat.out_free   = !out_valid || result.ready;

endmodule

// ===== rtl/wavelet_coeff_path_index_top.sv =====
// Top level: wavelet coefficient path index block, controller plus datapath.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   item     | in  | valid/ready   | step_number[15:0], leaf_index[6:0]
//   result   | out | valid/ready   | layer_number[2:0], coeff_index[16:0],
//            |     |               | last_of_path
//   cfg      | in  | valid/ready   | index[1:0], data[15:0]
//
// An item first maps its step to a node (grouping, split, divide by 2, 3 or 4), then walks
// the root and one layer per cycle through the single node update unit, L results in all,
// L the layer count in use (at most 8). A stalled result register holds the path walk.
// The next item is taken once the last result of the path is in the result register.
// Synchronous reset sets one time step and one layer; a layer count of zero gives no results.
module wavelet_coeff_path_index_top (
  input  logic       clk,
  input  logic       rst,
  wcp_item_if.sink   item,
  wcp_result_if.source result,
  wcp_cfg_if.sink    cfg
);
  import wcp_pkg::*;

  wcp_cmd_t  cmd;
  wcp_stat_t stat;

  wcp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wcp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .step_number (item.step_number),
    .leaf_index  (item.leaf_index),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .cfg         (cfg)
  );

endmodule

// ===== rtl/wcp_checker.sv =====
// Checker: port-level assertions on the wavelet coefficient path block, bound to the top level.
module wcp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [wcp_pkg::LayerW-1:0]  res_layer,
  input logic [wcp_pkg::CoeffW-1:0]  res_coeff,
  input logic                        res_last
);
  import wcp_pkg::*;

  logic item_acc;
  logic res_acc;

  assign item_acc = item_valid && item_ready;
  assign res_acc  = res_valid && res_ready;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_layer) && $stable(res_coeff)
      && $stable(res_last))
    else $error("result changed while stalled");

  a_layer_advance: assert property (@(posedge clk) disable iff (rst)
    res_acc && !res_last ##1 res_valid |-> res_layer == LayerW'($past(res_layer) + 1'b1))
    else $error("layer did not advance by one");

  a_path_root: assert property (@(posedge clk) disable iff (rst)
    res_acc && res_last ##1 res_valid |-> res_layer == '0)
    else $error("new path does not start at root");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> !res_valid || res_last)
    else $error("item taken while a path was still in flight");

endmodule

bind wavelet_coeff_path_index_top wcp_checker u_wcp_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_layer  (result.layer_number),
  .res_coeff  (result.coeff_index),
  .res_last   (result.last_of_path)
);
